[design/shu_pkg.sv]
// Shared types and constants for the selectable string hash unit.
// No dependencies; used by shu_step, selectable_string_hash_unit and shu_checker.
package shu_pkg;

    localparam int unsigned HASH_W = 32;
    localparam int unsigned SEL_W  = 4;
    localparam int unsigned LEN_W  = 16;

    // Scheme codes held in the selector register
    localparam logic [SEL_W-1:0] ALG_RS   = 4'd0;
    localparam logic [SEL_W-1:0] ALG_JS   = 4'd1;
    localparam logic [SEL_W-1:0] ALG_PJW  = 4'd2;
    localparam logic [SEL_W-1:0] ALG_ELF  = 4'd3;
    localparam logic [SEL_W-1:0] ALG_BKDR = 4'd4;
    localparam logic [SEL_W-1:0] ALG_SDB  = 4'd5;
    localparam logic [SEL_W-1:0] ALG_DJB  = 4'd6;
    localparam logic [SEL_W-1:0] ALG_DEK  = 4'd7;
    localparam logic [SEL_W-1:0] ALG_BP   = 4'd8;
    localparam logic [SEL_W-1:0] ALG_FNV  = 4'd9;
    localparam logic [SEL_W-1:0] ALG_AP   = 4'd10;

    localparam logic [HASH_W-1:0] RS_MULT_INIT = 32'd63689;
    localparam logic [HASH_W-1:0] RS_MULT_STEP = 32'd378551;
    localparam logic [HASH_W-1:0] JS_INIT      = 32'd1315423911;
    localparam logic [HASH_W-1:0] DJB_INIT     = 32'd5381;
    localparam logic [HASH_W-1:0] FNV_INIT     = 32'h811C_9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME    = 32'h0100_0193;
    localparam logic [HASH_W-1:0] AP_INIT      = 32'hAAAA_AAAA;
    localparam logic [HASH_W-1:0] BKDR_MULT    = 32'd131;
    localparam logic [HASH_W-1:0] TOP_NIBBLE   = 32'hF000_0000;

    typedef struct packed {
        logic [7:0]       char_byte;
        logic             first_byte;
        logic             last_byte;
        logic             empty_string;
        logic [LEN_W-1:0] string_length;
    } item_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] rs_mult;
        logic              pos_odd;
        logic              emit;
    } step_t;

endpackage

[design/shu_step.sv]
// One absorb step of the selected hash scheme, purely combinational.
// Depends on shu_pkg.
module shu_step #(
    parameter int LENGTH_BITS = 16
) (
    input  logic [shu_pkg::SEL_W-1:0]  sel,
    input  shu_pkg::item_t             item,
    input  logic [shu_pkg::HASH_W-1:0] hash,
    input  logic [shu_pkg::HASH_W-1:0] rs_mult,
    input  logic                       pos_odd,
    output shu_pkg::step_t             step
);

    localparam logic [shu_pkg::HASH_W-1:0] LEN_MASK =
        32'((33'd1 << LENGTH_BITS) - 33'd1);

    logic [shu_pkg::HASH_W-1:0] seed;
    logic [shu_pkg::HASH_W-1:0] init_val;
    logic [shu_pkg::HASH_W-1:0] h0;
    logic [shu_pkg::HASH_W-1:0] m0;
    logic                       p0;
    logic [shu_pkg::HASH_W-1:0] c;
    logic [shu_pkg::HASH_W-1:0] mul_a;
    logic [shu_pkg::HASH_W-1:0] mul_b;
    logic [shu_pkg::HASH_W-1:0] prod;
    logic [shu_pkg::HASH_W-1:0] pjw_t;
    logic [shu_pkg::HASH_W-1:0] pjw_x;
    logic [shu_pkg::HASH_W-1:0] h1;
    logic [shu_pkg::HASH_W-1:0] m1;

    assign seed = 32'(item.string_length) & LEN_MASK;

    always_comb
    begin
        case (sel)
            shu_pkg::ALG_JS:  init_val = shu_pkg::JS_INIT;
            shu_pkg::ALG_DJB: init_val = shu_pkg::DJB_INIT;
            shu_pkg::ALG_DEK: init_val = seed;
            shu_pkg::ALG_FNV: init_val = shu_pkg::FNV_INIT;
            shu_pkg::ALG_AP:  init_val = shu_pkg::AP_INIT;
            default:          init_val = '0;
        endcase
    end

    assign h0 = item.first_byte ? init_val : hash;
    assign m0 = item.first_byte ? shu_pkg::RS_MULT_INIT : rs_mult;
    assign p0 = item.first_byte ? 1'b0 : pos_odd;
    assign c  = {{24{item.char_byte[7]}}, item.char_byte};

    // one general multiplier shared by RS (h * mult) and AP (c * (h >> 3))
    assign mul_a = (sel == shu_pkg::ALG_AP) ? c : h0;
    assign mul_b = (sel == shu_pkg::ALG_AP) ? (h0 >> 3) : m0;
    assign prod  = mul_a * mul_b;

    // when the top nibble is clear this reduces to pjw_t itself
    assign pjw_t = (h0 << 4) + c;
    assign pjw_x = pjw_t & shu_pkg::TOP_NIBBLE;

    always_comb
    begin
        m1 = m0;
        case (sel)
            shu_pkg::ALG_RS:
            begin
                h1 = prod + c;
                m1 = m0 * shu_pkg::RS_MULT_STEP;
            end
            shu_pkg::ALG_JS:   h1 = h0 ^ ((h0 << 5) + c + (h0 >> 2));
            shu_pkg::ALG_PJW,
            shu_pkg::ALG_ELF:  h1 = (pjw_t ^ (pjw_x >> 24)) & ~pjw_x;
            shu_pkg::ALG_BKDR: h1 = (h0 * shu_pkg::BKDR_MULT) + c;
            shu_pkg::ALG_SDB:  h1 = c + (h0 << 6) + (h0 << 16) - h0;
            shu_pkg::ALG_DJB:  h1 = (h0 << 5) + h0 + c;
            shu_pkg::ALG_DEK:  h1 = ((h0 << 5) ^ (h0 >> 27)) ^ c;
            shu_pkg::ALG_BP:   h1 = (h0 << 7) ^ c;
            shu_pkg::ALG_FNV:  h1 = (h0 * shu_pkg::FNV_PRIME) ^ c;
            shu_pkg::ALG_AP:
            begin
                if (!p0)
                    h1 = h0 ^ ((h0 << 7) ^ prod);
                else
                    h1 = h0 ^ ~((h0 << 11) + (c ^ (h0 >> 5)));
            end
            default:           h1 = h0;
        endcase
    end

    always_comb
    begin
        if (item.empty_string)
        begin
            step.hash    = init_val;
            step.rs_mult = shu_pkg::RS_MULT_INIT;
            step.pos_odd = 1'b0;
            step.emit    = 1'b1;
        end
        else
        begin
            step.hash    = h1;
            step.rs_mult = m1;
            step.pos_odd = ~p0;
            step.emit    = item.last_byte;
        end
    end

endmodule

[design/selectable_string_hash_unit.sv]
// Top level of the selectable string hash unit: input register, state, result register.
// Depends on shu_pkg and shu_step.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one string byte per item with
//   first_byte, last_byte, empty_string and string_length. Output channel
//   (out_valid / out_stall) carries hash_value, one item per string, issued
//   for an item marked last or empty.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
//   scheme selector; cfg_ready is always high. Write it only while idle.
//   A result is computed from the item in the input register and held in the
//   output register. Throughput: one item per cycle while in_stall is low, set
//   by the update of the running hash, rs multiplier and parity registers.
//   A result waiting in the output register does not block input; in_stall
//   rises only when the item in the input register must emit a result while
//   the output register is full and stalled.
//   Reset clears the pipeline, sets the selector to RS and returns the
//   running state to its reset values (hash 0, RS multiplier 63689).
module selectable_string_hash_unit #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [shu_pkg::SEL_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  char_byte,
    input  logic                        first_byte,
    input  logic                        last_byte,
    input  logic                        empty_string,
    input  logic [shu_pkg::LEN_W-1:0]   string_length,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [shu_pkg::HASH_W-1:0]  hash_value
);

    logic [shu_pkg::SEL_W-1:0]  sel_reg;
    logic                       in_valid_reg;
    logic                       in_valid_next;
    shu_pkg::item_t             item_reg;
    logic [shu_pkg::HASH_W-1:0] hash_reg;
    logic [shu_pkg::HASH_W-1:0] rs_mult_reg;
    logic                       pos_odd_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [shu_pkg::HASH_W-1:0] out_hash_reg;
    shu_pkg::step_t             step;
    logic                       advance;
    logic                       accept;

    shu_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .sel     (sel_reg),
        .item    (item_reg),
        .hash    (hash_reg),
        .rs_mult (rs_mult_reg),
        .pos_odd (pos_odd_reg),
        .step    (step)
    );

    assign cfg_ready = 1'b1;

    // item in the input register moves on unless its result has nowhere to go
    assign advance  = in_valid_reg && !(step.emit && out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = (advance && step.emit) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= shu_pkg::ALG_RS;
            in_valid_reg  <= 1'b0;
            hash_reg      <= '0;
            rs_mult_reg   <= shu_pkg::RS_MULT_INIT;
            pos_odd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                sel_reg <= cfg_data;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                hash_reg    <= step.hash;
                rs_mult_reg <= step.rs_mult;
                pos_odd_reg <= step.pos_odd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.char_byte     <= char_byte;
            item_reg.first_byte    <= first_byte;
            item_reg.last_byte     <= last_byte;
            item_reg.empty_string  <= empty_string;
            item_reg.string_length <= string_length;
        end
        if (advance && step.emit)
            out_hash_reg <= step.hash;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

endmodule

[design/shu_checker.sv]
// Port-level checks for selectable_string_hash_unit, attached by bind.
// Depends on shu_pkg for widths.
module shu_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [shu_pkg::HASH_W-1:0] hash_value
);

    // a stalled result is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hash_value))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

    // input backs up only behind a stalled, full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // a fresh result must trace back to an accepted item
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching item");

endmodule

bind selectable_string_hash_unit shu_checker u_shu_checker (.*);
